// ===== sv/dmcs_pkg.sv =====
// Package for the DMC control step block: sizes, codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package dmcs_pkg;

  // Prediction horizon and fixed-point format
  localparam int HORIZON    = 256;
  localparam int FRAC_BITS  = 16;
  localparam int HIST_DEPTH = HORIZON - 1;

  // Field widths fixed by the interface
  localparam int DATA_W    = 32;
  localparam int CIDX_W    = 8;
  localparam int CFG_IDX_W = 1;

  // History walk index and coefficient RAM address
  localparam int JW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  // Increment history ring pointer; ring holds at least HORIZON words
  localparam int HPTR_W    = $clog2(HORIZON);
  localparam int HRAM_DEPTH = 2 ** HPTR_W;
  // Fill count of the increment history, holds 0..HIST_DEPTH
  localparam int CNT_W = $clog2(HORIZON);

  // Products are 33x32 signed; accumulator keeps headroom for HORIZON terms
  localparam int PROD_W = 2 * DATA_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(HORIZON) + 1;

  localparam logic signed [DATA_W-1:0] SETPOINT_RST = 32'sd131072;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Request kinds on the input channel
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 1'b0,
    REG_ERROR_GAIN = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MAC,
    ST_DRAIN,
    ST_FIN,
    ST_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic          load_sample; // latch measurement, clear accumulator
    logic          coef_we;     // coefficient transfer accepted
    logic          mul_err;     // multiply error_gain by setpoint error
    logic          rd_issue;    // read history entry rd_idx
    logic [JW-1:0] rd_idx;
    logic          fin;         // scale and saturate the sum
    logic          commit;      // update control, history, output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;      // products still in flight
    logic out_free;  // output register can take a result
  } stat_t;

endpackage

// ===== sv/dmcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dmcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dmcs_ctrl.sv =====
// Controller of the DMC control step: sequences error product, history walk,
// drain, scaling and commit. Depends on dmcs_pkg.
module dmcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_req_type,
  output logic            in_ready,
  input  dmcs_pkg::stat_t stat,
  output dmcs_pkg::cmd_t  cmd
);
  import dmcs_pkg::*;

  localparam logic [JW-1:0] LAST_IDX = JW'(HIST_DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [JW-1:0] idx_r, idx_nxt;

  // State and walk index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid && (in_req_type == REQ_SAMPLE)) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR, ST_MAC: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_MAC;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.rd_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_sample = in_valid && (in_req_type == REQ_SAMPLE);
        cmd.coef_we     = in_valid && (in_req_type == REQ_COEF);
      end
      ST_ERR: begin
        cmd.mul_err  = 1'b1;
        cmd.rd_issue = 1'b1;
      end
      ST_MAC:    cmd.rd_issue = 1'b1;
      ST_DRAIN:  ;
      ST_FIN:    cmd.fin = 1'b1;
      ST_COMMIT: cmd.commit = stat.out_free;
      default:   ;
    endcase
  end

endmodule

// ===== sv/dmcs_datapath.sv =====
// Datapath of the DMC control step: config registers, coefficient and
// increment history RAMs, shared multiplier, accumulator, output register.
// Depends on dmcs_pkg and dmcs_ram.
module dmcs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dmcs_pkg::cmd_t                 cmd,
  output dmcs_pkg::stat_t                stat,
  input  logic                           cfg_we,
  input  logic [dmcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmcs_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic [dmcs_pkg::CIDX_W-1:0]    in_coef_index,
  input  logic signed [dmcs_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [dmcs_pkg::DATA_W-1:0] in_measured_output,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [dmcs_pkg::DATA_W-1:0] out_control_out,
  output logic signed [dmcs_pkg::DATA_W-1:0] out_increment_out,
  output logic                           out_saturated
);
  import dmcs_pkg::*;

  // Configuration
  logic signed [DATA_W-1:0] setpoint_r, error_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SETPOINT_RST;
      error_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:   setpoint_r   <= cfg_wdata;
        REG_ERROR_GAIN: error_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficient RAM; out-of-range indexes are dropped
  logic                     coef_wr;
  logic [DATA_W-1:0]        coef_rdata;

  assign coef_wr = cmd.coef_we && (int'(in_coef_index) < HIST_DEPTH);

  dmcs_ram #(.WIDTH(DATA_W), .DEPTH(HIST_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_wr),
    .waddr (JW'(in_coef_index)),
    .wdata (in_coef_value),
    .raddr (cmd.rd_idx),
    .rdata (coef_rdata)
  );

  // Increment history ring: entry j lives at base_r + j, newest at base_r
  logic [HPTR_W-1:0] base_r;
  logic [CNT_W-1:0]  fill_r;
  logic [DATA_W-1:0] hist_rdata;
  logic signed [DATA_W-1:0] inc_r;

  dmcs_ram #(.WIDTH(DATA_W), .DEPTH(HRAM_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (base_r - 1'b1),
    .wdata (inc_r),
    .raddr (base_r + HPTR_W'(cmd.rd_idx)),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      fill_r <= '0;
    end else if (cmd.commit) begin
      base_r <= base_r - 1'b1;
      if (int'(fill_r) < HIST_DEPTH) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Read stage: entries past the fill count read as zero
  logic rd_vld_r, hvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    hvalid_r <= CNT_W'(cmd.rd_idx) < fill_r;
  end

  // Shared multiplier, registered product
  logic signed [DATA_W-1:0] meas_r;
  logic signed [DATA_W:0]   err;
  logic signed [DATA_W-1:0] hist_val;
  logic signed [DATA_W:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_full, prod_r;
  logic                     prod_vld_r, prod_sub_r;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      meas_r <= in_measured_output;
    end
  end

  assign err       = {setpoint_r[DATA_W-1], setpoint_r} - {meas_r[DATA_W-1], meas_r};
  assign hist_val  = hvalid_r ? hist_rdata : '0;
  assign mul_a     = cmd.mul_err ? err : {hist_val[DATA_W-1], hist_val};
  assign mul_b     = cmd.mul_err ? error_gain_r : coef_rdata;
  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_err || rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_full;
    prod_sub_r <= !cmd.mul_err;
  end

  // Accumulator: error term added, history terms subtracted
  logic signed [ACC_W-1:0] acc_r, prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= prod_sub_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  assign stat.busy = rd_vld_r || prod_vld_r;

  // Floor shift and saturate the increment
  logic signed [ACC_W-1:0] acc_sh;
  logic                    inc_ovf, clip_r;

  assign acc_sh  = acc_r >>> FRAC_BITS;
  assign inc_ovf = !((&acc_sh[ACC_W-1:DATA_W-1]) || !(|acc_sh[ACC_W-1:DATA_W-1]));

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      clip_r <= inc_ovf;
      if (inc_ovf) begin
        inc_r <= acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        inc_r <= acc_sh[DATA_W-1:0];
      end
    end
  end

  // Control update with saturation
  logic signed [DATA_W-1:0] last_r, ctl_sat;
  logic signed [DATA_W:0]   ctl_sum;
  logic                     ctl_ovf;

  assign ctl_sum = {last_r[DATA_W-1], last_r} + {inc_r[DATA_W-1], inc_r};
  assign ctl_ovf = ctl_sum[DATA_W] != ctl_sum[DATA_W-1];
  assign ctl_sat = ctl_ovf ? (ctl_sum[DATA_W] ? SAT_MIN : SAT_MAX) : ctl_sum[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cmd.commit) begin
      last_r <= ctl_sat;
    end
  end

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_control_out   <= ctl_sat;
      out_increment_out <= inc_r;
      out_saturated     <= clip_r || ctl_ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ===== sv/dmc_control_step_unit.sv =====
// DMC control step unit. A coefficient write (req_type 1) gives no result.
// A sample (req_type 0) holds off the next item until its result is
// committed: one multiply-accumulate per cycle, first the error term, then
// the HORIZON - 1 history entries read from the coefficient RAM and the
// increment history RAM, then pipeline drain, scaling and the commit, which
// waits until the output register can take the result. The increment
// history needs no clearing pass after reset; a fill count masks entries
// not yet written. A finished result waits in the output register while the
// next item is taken.
// Depends on dmcs_pkg, dmcs_ctrl, dmcs_datapath and dmcs_ram.
module dmc_control_step_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dmcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmcs_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [dmcs_pkg::CIDX_W-1:0]        in_coef_index,
  input  logic signed [dmcs_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [dmcs_pkg::DATA_W-1:0] in_measured_output,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dmcs_pkg::DATA_W-1:0] out_control_out,
  output logic signed [dmcs_pkg::DATA_W-1:0] out_increment_out,
  output logic                               out_saturated
);
  import dmcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dmcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  dmcs_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_coef_index      (in_coef_index),
    .in_coef_value      (in_coef_value),
    .in_measured_output (in_measured_output),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_control_out    (out_control_out),
    .out_increment_out  (out_increment_out),
    .out_saturated      (out_saturated)
  );

`ifndef SYNTHESIS
  // A result is only committed when the output register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("result committed over a pending output");

  // New items are only taken with the multiply pipeline empty
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.busy)
    else $error("input ready while products in flight");

  // A coefficient transfer never produces a result
  a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_COEF) && !out_valid) |=> !out_valid)
    else $error("coefficient write produced a result");
`endif

endmodule
